@@ design/cfr_pkg.sv @@
package cfr_pkg;

  localparam int unsigned HDR_BYTES = 10;

  localparam logic [2:0] ST_TAKEN     = 3'd0;
  localparam logic [2:0] ST_STORED    = 3'd1;
  localparam logic [2:0] ST_COMPLETE  = 3'd2;
  localparam logic [2:0] ST_MALFORMED = 3'd3;
  localparam logic [2:0] ST_BYTE      = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;
  localparam logic [2:0] ST_BUSY      = 3'd6;

  // Control strobes from the sequencer to the frame store.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic sz_wr;
    logic sz_rd;
    logic clr;
  } fs_ctl_t;

endpackage

@@ design/cfr_stage_buf.sv @@
module cfr_stage_buf #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/cfr_frame_store.sv @@
module cfr_frame_store #(
  parameter int unsigned MAX_SLOTS = 64,
  parameter longint unsigned DEPTH = 65536,
  parameter int unsigned AW        = 16,
  parameter int unsigned SW        = 6,
  parameter int unsigned ZW        = 11
) (
  input  logic            clk,
  input  logic            rst_n,
  input  cfr_pkg::fs_ctl_t ctl,
  input  logic [AW-1:0]   wr_addr,
  input  logic [7:0]      wr_data,
  input  logic [AW-1:0]   rd_addr,
  output logic [7:0]      rd_data,
  input  logic [SW-1:0]   slot,
  input  logic [ZW-1:0]   sz_wdata,
  output logic [ZW-1:0]   sz_rdata,
  output logic [MAX_SLOTS-1:0] slot_valid
);

  logic [7:0]    mem [DEPTH];
  logic [ZW-1:0] size_mem [MAX_SLOTS];
  logic [7:0]    rd_data_r;
  logic [ZW-1:0] sz_rdata_r;
  logic [MAX_SLOTS-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (ctl.sz_wr) begin
      size_mem[slot] <= sz_wdata;
    end
    if (ctl.sz_rd) begin
      sz_rdata_r <= size_mem[slot];
    end
  end

  // A slot holds data only once its size was written for the current frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.clr) begin
      valid_r <= '0;
    end else if (ctl.sz_wr) begin
      valid_r[slot] <= 1'b1;
    end
  end

  assign rd_data    = rd_data_r;
  assign sz_rdata   = sz_rdata_r;
  assign slot_valid = valid_r;

endmodule

@@ design/chunked_frame_reassembler.sv @@
// Chunked frame reassembler.
// Input channel in_*: in_tuser selects the command (0 = datagram byte, 1 = pull one
// byte of the ready frame), in_tdata carries the byte, in_tlast marks the last byte
// of a datagram. Every input item yields exactly one result item on out_*.
// Result tdata: status, payload byte and current frame id; out_tlast marks the
// last byte of a reassembled frame.
// Timing: a header or payload byte and a refused or idle command are answered from the
// idle state, and the result is registered at the accepting edge. A malformed datagram
// end passes through the check state. A valid datagram end passes through the check,
// copy and finish states; the copy moves the staged payload into the chunk memory at
// one byte per cycle. A pull passes through the scan and read states, plus a second
// scan state after the last byte of a chunk; the scans step over empty slots.
// Reset clears the header, counters, frame id and all slot valid flags at once;
// no memory clearing pass is needed. A result waits in the output register while
// the receiver stalls, and the block still takes one more item with its result in a holding
// register; further items wait until the output register drains.
module chunked_frame_reassembler #(
  parameter int unsigned MAX_SLOTS       = 64,
  parameter int unsigned MAX_CHUNK_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tlast,   // end_of_datagram
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // status[2:0], out_byte[10:3], out_frame_id[42:11], zeros
  output logic        out_tlast   // out_last
);

  localparam int unsigned SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned SCW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned OW  = (MAX_CHUNK_BYTES > 1) ? $clog2(MAX_CHUNK_BYTES) : 1;
  localparam int unsigned ZW  = $clog2(MAX_CHUNK_BYTES + 1);
  localparam int unsigned CW  = $clog2(MAX_CHUNK_BYTES + 12);
  localparam int unsigned CAP = cfr_pkg::HDR_BYTES + MAX_CHUNK_BYTES + 1;
  localparam longint unsigned DEPTH = longint'(MAX_SLOTS) * longint'(MAX_CHUNK_BYTES);
  localparam int unsigned AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_COPY  = 8'b0000_0100,
    S_FIN   = 8'b0000_1000,
    S_SCAN  = 8'b0001_0000,
    S_RD    = 8'b0010_0000,
    S_SCAN2 = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [63:0] hdr0_r, hdr0_nxt;
  logic [15:0] hdr1_r, hdr1_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0] cur_r, cur_nxt;
  logic [15:0] exp_r, exp_nxt;
  logic [15:0] rc_r, rc_nxt;
  logic [15:0] tot_r, tot_nxt;
  logic ro_r, ro_nxt;
  logic [SW-1:0] rs_r, rs_nxt;
  logic [ZW-1:0] off_r, off_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [ZW-1:0] csz_r, csz_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [ZW-1:0] cp_r, cp_nxt;
  logic [SCW-1:0] scan_r, scan_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic [2:0] rst_st_r, rst_st_nxt;
  logic [7:0] rbyte_r, rbyte_nxt;
  logic rlast_r, rlast_nxt;
  logic ov_r, ov_nxt;
  logic [2:0] ost_r, ost_nxt;
  logic [7:0] obyte_r, obyte_nxt;
  logic olast_r, olast_nxt;
  logic [31:0] ofid_r, ofid_nxt;

  logic res_v;
  logic [2:0] res_st;
  logic [7:0] res_byte;
  logic res_last;
  state_t st_after;
  logic out_free, acc, malformed;

  logic stg_we, stg_re;
  logic [OW-1:0] stg_waddr, stg_raddr;
  logic [7:0] stg_q;

  cfr_pkg::fs_ctl_t fs_ctl;
  logic [AW-1:0] fs_waddr, fs_raddr;
  logic [7:0] fs_q;
  logic [SW-1:0] fs_slot;
  logic [ZW-1:0] fs_sz_q;
  logic [MAX_SLOTS-1:0] slot_valid;

  cfr_stage_buf #(.DEPTH(MAX_CHUNK_BYTES), .AW(OW)) u_stage (
    .clk(clk), .we(stg_we), .waddr(stg_waddr), .wdata(in_tdata),
    .re(stg_re), .raddr(stg_raddr), .rdata(stg_q)
  );

  cfr_frame_store #(
    .MAX_SLOTS(MAX_SLOTS), .DEPTH(DEPTH), .AW(AW), .SW(SW), .ZW(ZW)
  ) u_store (
    .clk(clk), .rst_n(rst_n), .ctl(fs_ctl), .wr_addr(fs_waddr), .wr_data(stg_q),
    .rd_addr(fs_raddr), .rd_data(fs_q), .slot(fs_slot), .sz_wdata(csz_r),
    .sz_rdata(fs_sz_q), .slot_valid(slot_valid)
  );

  assign out_free  = !ov_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;

  assign malformed = (cnt_r < CW'(cfr_pkg::HDR_BYTES)) || (hdr1_r == 16'd0) ||
                     (17'(hdr1_r) > 17'(MAX_CHUNK_BYTES)) ||
                     (17'(cnt_r) != 17'(hdr1_r) + 17'(cfr_pkg::HDR_BYTES)) ||
                     (hdr0_r[47:32] >= hdr0_r[63:48]) ||
                     (17'(hdr0_r[47:32]) >= 17'(MAX_SLOTS)) ||
                     ((hdr0_r[31:0] == cur_r) && (exp_r != 16'd0) &&
                      (exp_r != hdr0_r[63:48]));

  always_comb begin
    state_nxt = state_r;
    hdr0_nxt = hdr0_r; hdr1_nxt = hdr1_r; cnt_nxt = cnt_r;
    cur_nxt = cur_r; exp_nxt = exp_r; rc_nxt = rc_r; tot_nxt = tot_r;
    ro_nxt = ro_r; rs_nxt = rs_r; off_nxt = off_r;
    slot_nxt = slot_r; csz_nxt = csz_r; base_nxt = base_r; cp_nxt = cp_r;
    scan_nxt = scan_r; byte_nxt = byte_r;
    rst_st_nxt = rst_st_r; rbyte_nxt = rbyte_r; rlast_nxt = rlast_r;
    ov_nxt = ov_r && !out_tready;
    ost_nxt = ost_r; obyte_nxt = obyte_r; olast_nxt = olast_r; ofid_nxt = ofid_r;
    res_v = 1'b0; res_st = cfr_pkg::ST_TAKEN; res_byte = 8'd0; res_last = 1'b0;
    st_after = S_IDLE;
    stg_we = 1'b0; stg_re = 1'b0;
    stg_waddr = OW'(cnt_r - CW'(cfr_pkg::HDR_BYTES));
    stg_raddr = OW'(cp_r);
    fs_ctl = '0;
    fs_waddr = base_r + AW'(cp_r) - AW'(1);
    fs_raddr = AW'(scan_r[SW-1:0]) * AW'(MAX_CHUNK_BYTES) + AW'(off_r);
    fs_slot = slot_r;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_tuser) begin
            if (ro_r) begin
              scan_nxt = SCW'(rs_r);
              state_nxt = S_SCAN;
            end else begin
              res_v = 1'b1; res_st = cfr_pkg::ST_EMPTY;
            end
          end else if (ro_r) begin
            res_v = 1'b1; res_st = cfr_pkg::ST_BUSY;
          end else begin
            if (cnt_r < CW'(8)) begin
              hdr0_nxt[8*cnt_r[2:0] +: 8] = in_tdata;
            end else if (cnt_r < CW'(cfr_pkg::HDR_BYTES)) begin
              hdr1_nxt[8*cnt_r[0] +: 8] = in_tdata;
            end else if (cnt_r < CW'(cfr_pkg::HDR_BYTES + MAX_CHUNK_BYTES)) begin
              stg_we = 1'b1;
            end
            if (cnt_r < CW'(CAP)) begin
              cnt_nxt = cnt_r + CW'(1);
            end
            if (in_tlast) begin
              state_nxt = S_CHECK;
            end else begin
              res_v = 1'b1; res_st = cfr_pkg::ST_TAKEN;
            end
          end
        end
      end
      S_CHECK: begin
        hdr0_nxt = '0; hdr1_nxt = '0; cnt_nxt = '0;
        if (malformed) begin
          res_v = 1'b1; res_st = cfr_pkg::ST_MALFORMED;
        end else begin
          // A new frame id drops every slot of the old frame.
          if (hdr0_r[31:0] != cur_r) begin
            fs_ctl.clr = 1'b1;
            rc_nxt = 16'd0;
            cur_nxt = hdr0_r[31:0];
          end
          slot_nxt = hdr0_r[32 +: SW];
          csz_nxt = ZW'(hdr1_r);
          tot_nxt = hdr0_r[63:48];
          base_nxt = AW'(hdr0_r[32 +: SW]) * AW'(MAX_CHUNK_BYTES);
          cp_nxt = '0;
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        // Staging read leads the chunk write: each byte read is written in the next cycle.
        stg_re = (cp_r < csz_r);
        fs_ctl.wr_en = (cp_r != '0);
        cp_nxt = cp_r + ZW'(1);
        if (cp_r == csz_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        fs_ctl.sz_wr = 1'b1;
        exp_nxt = tot_r;
        rc_nxt = rc_r + 16'd1;
        res_v = 1'b1;
        if (rc_r + 16'd1 == tot_r) begin
          ro_nxt = 1'b1; rs_nxt = '0; off_nxt = '0;
          res_st = cfr_pkg::ST_COMPLETE;
        end else begin
          res_st = cfr_pkg::ST_STORED;
        end
      end
      S_SCAN: begin
        fs_slot = scan_r[SW-1:0];
        if (scan_r >= SCW'(MAX_SLOTS)) begin
          ro_nxt = 1'b0;
          res_v = 1'b1; res_st = cfr_pkg::ST_EMPTY;
        end else if (slot_valid[scan_r[SW-1:0]]) begin
          fs_ctl.rd_en = 1'b1;
          fs_ctl.sz_rd = 1'b1;
          rs_nxt = scan_r[SW-1:0];
          state_nxt = S_RD;
        end else begin
          scan_nxt = scan_r + SCW'(1);
        end
      end
      S_RD: begin
        if (off_r + ZW'(1) >= fs_sz_q) begin
          off_nxt = '0;
          scan_nxt = scan_r + SCW'(1);
          byte_nxt = fs_q;
          state_nxt = S_SCAN2;
        end else begin
          off_nxt = off_r + ZW'(1);
          res_v = 1'b1; res_st = cfr_pkg::ST_BYTE; res_byte = fs_q;
        end
      end
      S_SCAN2: begin
        if (scan_r >= SCW'(MAX_SLOTS)) begin
          ro_nxt = 1'b0; rs_nxt = '0; off_nxt = '0;
          res_v = 1'b1; res_st = cfr_pkg::ST_BYTE; res_byte = byte_r; res_last = 1'b1;
        end else if (slot_valid[scan_r[SW-1:0]]) begin
          rs_nxt = scan_r[SW-1:0];
          res_v = 1'b1; res_st = cfr_pkg::ST_BYTE; res_byte = byte_r;
        end else begin
          scan_nxt = scan_r + SCW'(1);
        end
      end
      S_EMIT: begin
        res_v = 1'b1; res_st = rst_st_r; res_byte = rbyte_r; res_last = rlast_r;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (res_v) begin
      if (out_free) begin
        ov_nxt = 1'b1;
        ost_nxt = res_st; obyte_nxt = res_byte; olast_nxt = res_last;
        ofid_nxt = cur_nxt;
        state_nxt = st_after;
      end else begin
        rst_st_nxt = res_st; rbyte_nxt = res_byte; rlast_nxt = res_last;
        state_nxt = S_EMIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hdr0_r <= '0; hdr1_r <= '0; cnt_r <= '0;
      cur_r <= '0; exp_r <= '0; rc_r <= '0;
      ro_r <= 1'b0; rs_r <= '0; off_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hdr0_r <= hdr0_nxt; hdr1_r <= hdr1_nxt; cnt_r <= cnt_nxt;
      cur_r <= cur_nxt; exp_r <= exp_nxt; rc_r <= rc_nxt;
      ro_r <= ro_nxt; rs_r <= rs_nxt; off_r <= off_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tot_r <= tot_nxt; slot_r <= slot_nxt; csz_r <= csz_nxt; base_r <= base_nxt;
    cp_r <= cp_nxt; scan_r <= scan_nxt; byte_r <= byte_nxt;
    rst_st_r <= rst_st_nxt; rbyte_r <= rbyte_nxt; rlast_r <= rlast_nxt;
    ost_r <= ost_nxt; obyte_r <= obyte_nxt; olast_r <= olast_nxt; ofid_r <= ofid_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {5'd0, ofid_r, obyte_r, ost_r};

  a_no_stage_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
    ro_r |-> !stg_we) else $error("staging write during readout");
  a_no_chunk_write_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
    ro_r |-> !fs_ctl.wr_en) else $error("chunk write during readout");
  a_last_is_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[2:0] == cfr_pkg::ST_BYTE))
    else $error("last flag on a non-byte result");
  a_complete_starts_readout: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && rc_r + 16'd1 == tot_r) |=> ro_r)
    else $error("completed frame did not enter readout");

endmodule
